FILE: rtl/core/sha512_pkg.sv
// Package for the SHA-512 / SHA-384 hash engine: types, constants, round functions.
// Used by the engine's modules and by its input and output interfaces.
`default_nettype none
package sha512_pkg;

  localparam int unsigned WordW = 64;

  typedef logic [WordW-1:0] word_t;

  // Payload of one input beat.
  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_item;
  } in_beat_t;

  // Payload of one output beat.
  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StFold,
    StPadFill,
    StEmit
  } state_e;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic       load_work;
    logic       do_round;
    logic       fold;
    logic       init_hash;
    logic       wr_sched;
    logic [3:0] wr_slot;
    word_t      wr_data;
    logic [6:0] round;
  } dp_ctrl_t;

  localparam word_t Init512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t Init384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam word_t RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t a);
    big_sigma0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t e);
    big_sigma1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t y);
    small_sigma1 = rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha512_in_if.sv
// Valid/ready channel interface carrying the hash engine's input beats.
// Depends on sha512_pkg for the payload types.
`default_nettype none
interface sha512_in_if import sha512_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha512_out_if.sv
// Valid/ready channel interface carrying digest beats.
// Depends on sha512_pkg for the payload type.
`default_nettype none
interface sha512_out_if import sha512_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha512_cfg_if.sv
// Valid/ready write channel for the digest mode register.
// Stand-alone; no package types needed.
`default_nettype none
interface sha512_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha512_sha384_hash_engine.sv
// Top level of the SHA-512 / SHA-384 hash engine.
// Depends on sha512_pkg, the channel interfaces, sha512_ctrl and sha512_round.
//
// Usage: message words arrive as beats on in_ch, one 64-bit big-endian word per beat,
// with a count of valid leading bytes and a last flag. Each sixteenth word starts
// the 80-round compression, one round per cycle on the shared round unit, then a fold
// step; in_ch is not ready meanwhile, so no word is taken until the block is folded.
// On the last beat the tail is padded one slot per cycle (a second block when the
// length does not fit), compressed, and then 8 digest beats (mode 0, SHA-512) or 6
// (mode 1, SHA-384) appear on out_ch, word 0 first. The output holds each beat until
// out_ch.ready is high; a stall simply stretches the emit phase. The mode register on
// cfg_ch is taken only while idle; a write drops any message in progress and loads the
// initial value. Reset selects SHA-512, clears the byte count and loads the SHA-512
// initial value.
`default_nettype none
module sha512_sha384_hash_engine import sha512_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch,
  sha512_cfg_if.sink   cfg_ch
);
  dp_ctrl_t   ctrl;
  logic       mode;
  logic [2:0] rd_idx;
  word_t      hash_word;

  sha512_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_data_i (in_ch.data), .in_ready_o (in_ch.ready),
    .out_valid_o (out_ch.valid), .out_data_o (out_ch.data), .out_ready_i (out_ch.ready),
    .cfg_valid_i (cfg_ch.valid), .cfg_data_i (cfg_ch.data), .cfg_ready_o (cfg_ch.ready),
    .mode_o (mode), .ctrl_o (ctrl), .rd_idx_o (rd_idx), .hash_i (hash_word)
  );

  sha512_round u_round (
    .clk_i, .rst_ni, .ctrl_i (ctrl), .mode_i (mode), .rd_idx_i (rd_idx), .hash_o (hash_word)
  );

  // No input beat is taken while digest beats are on offer.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready) else $error("input taken during digest output");

  // Digest index advances by one after each taken non-final beat.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.ready && !out_ch.data.last_word |=>
      out_ch.valid && out_ch.data.word_index == $past(out_ch.data.word_index) + 3'd1)
    else $error("digest index did not advance");

  // Rounds and datapath writes never overlap.
  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.do_round, ctrl.wr_sched, ctrl.fold})) else $error("datapath conflict");
endmodule
`default_nettype wire

FILE: rtl/core/sha512_round.sv
// Round datapath: working variables, 16-word schedule window and hash words.
// One shared round unit does a schedule update and a compression round per cycle.
`default_nettype none
module sha512_round import sha512_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire dp_ctrl_t ctrl_i,
  input  wire logic     mode_i,
  input  wire logic [2:0] rd_idx_i,
  output word_t         hash_o
);
  word_t hash_q [8];
  word_t work_q [8];
  word_t sched_q [16];
  word_t w_t, t1, t2, x, y;
  logic [3:0] slot;

  assign slot = ctrl_i.round[3:0];

  // Schedule word for this round, expanded in place from round 16 on.
  always_comb begin
    x   = sched_q[slot + 4'd1];
    y   = sched_q[slot + 4'd14];
    w_t = sched_q[slot];
    if (ctrl_i.round >= 7'd16) begin
      w_t = sched_q[slot] + small_sigma0(x) + sched_q[slot + 4'd9] + small_sigma1(y);
    end
    t1 = work_q[7] + big_sigma1(work_q[4])
       + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
       + RoundK[ctrl_i.round] + w_t;
    t2 = big_sigma0(work_q[0])
       + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
  end

  // Schedule window: written by message beats and by the expansion.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_sched) begin
      sched_q[ctrl_i.wr_slot] <= ctrl_i.wr_data;
    end else if (ctrl_i.do_round) begin
      sched_q[slot] <= w_t;
    end
  end

  // Working variables and chaining value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= Init512[i];
        work_q[i] <= '0;
      end
    end else if (ctrl_i.init_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= mode_i ? Init384[i] : Init512[i];
        work_q[i] <= '0;
      end
    end else if (ctrl_i.load_work) begin
      for (int i = 0; i < 8; i++) work_q[i] <= hash_q[i];
    end else if (ctrl_i.do_round) begin
      for (int i = 1; i < 8; i++) work_q[i] <= work_q[i-1];
      work_q[4] <= work_q[3] + t1;
      work_q[0] <= t1 + t2;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
    end
  end

  assign hash_o = hash_q[rd_idx_i];
endmodule
`default_nettype wire

FILE: rtl/core/sha512_ctrl.sv
// Sequencer: takes message beats, pads the tail, runs 80 rounds per block, emits the digest.
// Depends on sha512_pkg; drives sha512_round through a dp_ctrl_t bundle.
`default_nettype none
module sha512_ctrl import sha512_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire in_beat_t  in_data_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output out_beat_t      out_data_o,
  input  wire logic      out_ready_i,
  input  wire logic      cfg_valid_i,
  input  wire logic      cfg_data_i,
  output logic           cfg_ready_o,
  output logic           mode_o,
  output dp_ctrl_t       ctrl_o,
  output logic [2:0]     rd_idx_o,
  input  wire word_t     hash_i
);
  state_e     state_q, state_d;
  logic [3:0] pos_q, pos_d;
  logic [6:0] rnd_q, rnd_d;
  logic [63:0] bytes_q, bytes_d;
  logic       mode_q;
  logic       tail_q, tail_d;       // padding in progress
  // 2: pad word still due, 3: zeros to the block end with the length in the next block,
  // 1: zeros then the length in this block, 0: nothing left to place.
  logic [1:0] pend_q, pend_d;
  word_t      hold_q, hold_d;       // pad word waiting for a free slot
  logic [2:0] oidx_q, oidx_d;
  logic [3:0] nb;
  word_t      keep, padw, fill;
  logic       in_fire, cnt_words, last_out;

  assign in_fire  = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  // A mode write loads the new mode's initial value in the same cycle.
  assign mode_o   = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;
  assign last_out = mode_q ? (oidx_q == 3'd5) : (oidx_q == 3'd7);

  // Tail word: keep the valid bytes, then the pad byte.
  always_comb begin
    nb   = (in_data_i.valid_bytes > 4'd8) ? 4'd8 : in_data_i.valid_bytes;
    keep = (nb == 4'd0) ? '0 : ~(64'h0) << (7'd64 - {nb, 3'b000});
    padw = (in_data_i.message_word & keep) | ({56'h0, PadByte} << (7'd56 - {nb, 3'b000}));
    if (nb == 4'd8) padw = '0;
  end

  // Word to place in the next free slot during padding.
  always_comb begin
    fill = '0;
    if (pend_q == 2'd2) fill = hold_q;
    else if (pend_q == 2'd1 && pos_q == 4'd14) fill = {61'h0, bytes_q[63:61]};
    else if (pend_q == 2'd1 && pos_q == 4'd15) fill = {bytes_q[60:0], 3'b000};
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    pos_d = pos_q; rnd_d = rnd_q; bytes_d = bytes_q;
    tail_d = tail_q; pend_d = pend_q; hold_d = hold_q; oidx_d = oidx_q;
    cnt_words = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (!in_data_i.last_item) begin
            bytes_d = bytes_q + 64'd8;
            pos_d = pos_q + 4'd1;
            cnt_words = 1'b1;
          end else begin
            bytes_d = bytes_q + {60'h0, nb};
            tail_d = 1'b1;
            if (nb == 4'd8) begin
              pos_d = pos_q + 4'd1;
              pend_d = 2'd2;
              hold_d = {PadByte, 56'h0};
              cnt_words = 1'b1;
            end else begin
              pend_d = 2'd2;
              hold_d = (nb == 4'd0) ? {PadByte, 56'h0} : padw;
            end
          end
          if (cnt_words && pos_q == 4'd15) begin
            state_d = StRound; rnd_d = '0;
          end else if (in_data_i.last_item) begin
            state_d = StPadFill;
          end
        end
      end
      StPadFill: begin
        pos_d = pos_q + 4'd1;
        // The length fits behind the pad word only when the pad lands before slot 14.
        case (pend_q)
          2'd2: pend_d = (pos_q == 4'd14) ? 2'd3 : 2'd1;
          2'd3: if (pos_q == 4'd15) pend_d = 2'd1;
          2'd1: if (pos_q == 4'd15) pend_d = 2'd0;
          default: pend_d = pend_q;
        endcase
        if (pos_q == 4'd15) begin
          state_d = StRound; rnd_d = '0;
        end
      end
      StRound: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd79) begin
          state_d = StFold; rnd_d = '0;
        end
      end
      StFold: begin
        if (!tail_q) state_d = StIdle;
        else begin
          // After the last length block the digest is due; otherwise keep padding.
          state_d = (pend_q == 2'd0) ? StEmit : StPadFill;
        end
        oidx_d = '0;
      end
      StEmit: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (last_out) begin
            state_d = StIdle; tail_d = 1'b0; bytes_d = '0; pos_d = '0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath control.
  always_comb begin
    ctrl_o = '0;
    ctrl_o.round = rnd_q;
    case (state_q)
      StIdle: begin
        ctrl_o.wr_sched = in_fire && (!in_data_i.last_item || nb == 4'd8);
        ctrl_o.wr_slot  = pos_q;
        ctrl_o.wr_data  = in_data_i.message_word;
        ctrl_o.load_work = in_fire && cnt_words && pos_q == 4'd15;
      end
      StPadFill: begin
        ctrl_o.wr_sched = 1'b1;
        ctrl_o.wr_slot  = pos_q;
        ctrl_o.wr_data  = fill;
        ctrl_o.load_work = (pos_q == 4'd15);
      end
      StRound: ctrl_o.do_round = 1'b1;
      StFold:  ctrl_o.fold = 1'b1;
      StEmit:  ctrl_o.init_hash = out_ready_i && last_out;
      default: ctrl_o = '0;
    endcase
    if (cfg_valid_i && cfg_ready_o) ctrl_o.init_hash = 1'b1;
  end

  assign rd_idx_o    = oidx_q;
  assign out_valid_o = (state_q == StEmit);
  assign out_data_o  = '{digest_word: hash_i, word_index: oidx_q, last_word: last_out};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      rnd_q   <= '0;
      bytes_q <= '0;
      mode_q  <= 1'b0;
      tail_q  <= 1'b0;
      pend_q  <= '0;
      oidx_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q  <= cfg_data_i;
      pos_q   <= '0;
      bytes_q <= '0;
      tail_q  <= 1'b0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
      bytes_q <= bytes_d;
      tail_q  <= tail_d;
      pend_q  <= pend_d;
      oidx_q  <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_pkg.sv
// Testbench package: the digest scoreboard class, which predicts SHA-512 / SHA-384 digests and checks them.
// Depends on sha512_pkg for the beat types and the hash constants.
package tb_pkg;
  import sha512_pkg::*;

  class digest_scoreboard;
    bit        mode_384;
    word_t     chain [8];
    word_t     block_buf [16];
    int        slot;
    word_t     byte_count;
    out_beat_t pending_digest [$];
    int        error_count;

    function new();
      mode_384 = 1'b0;
      error_count = 0;
      restart();
    endfunction

    // Load the initial value of the current mode and drop any partial message.
    function void restart();
      for (int i = 0; i < 8; i++) begin
        chain[i] = mode_384 ? Init384[i] : Init512[i];
      end
      slot = 0;
      byte_count = '0;
    endfunction

    function void set_mode(bit m);
      mode_384 = m;
      restart();
    endfunction

    local function word_t ror64(word_t x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    // Run the 80 rounds over the buffered block and fold into the chaining value.
    local function void compress();
      word_t v [8];
      word_t w [80];
      word_t t1;
      word_t t2;
      for (int t = 0; t < 16; t++) begin
        w[t] = block_buf[t];
      end
      for (int t = 16; t < 80; t++) begin
        w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
               + (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
      end
      v = chain;
      for (int t = 0; t < 80; t++) begin
        t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
        t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int i = 7; i > 0; i--) begin
          v[i] = v[i-1];
        end
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
        chain[i] = chain[i] + v[i];
      end
    endfunction

    local function void append(word_t w);
      block_buf[slot] = w;
      slot = (slot + 1) % 16;
      if (slot == 0) begin
        compress();
      end
    endfunction

    // Note an accepted input beat; a last beat queues the digest words.
    function void note_input(in_beat_t b);
      int        nb;
      word_t     tail;
      word_t     keep;
      int        cnt;
      out_beat_t o;
      if (!b.last_item) begin
        byte_count = byte_count + 8;
        append(b.message_word);
        return;
      end
      nb = (b.valid_bytes > 8) ? 8 : int'(b.valid_bytes);
      byte_count = byte_count + nb;
      if (nb == 8) begin
        append(b.message_word);
        tail = {8'h80, 56'h0};
      end else if (nb == 0) begin
        tail = {8'h80, 56'h0};
      end else begin
        keep = ~64'h0 << (64 - 8 * nb);
        tail = (b.message_word & keep) | (64'h80 << (56 - 8 * nb));
      end
      append(tail);
      while (slot != 14) begin
        append('0);
      end
      append(byte_count >> 61);
      append(byte_count << 3);
      cnt = mode_384 ? 6 : 8;
      for (int i = 0; i < cnt; i++) begin
        o.digest_word = chain[i];
        o.word_index = 3'(i);
        o.last_word = (i == cnt - 1);
        pending_digest.push_back(o);
      end
      restart();
    endfunction

    // Compare one output beat with the oldest expected digest word.
    function void check_output(out_beat_t got);
      out_beat_t exp_b;
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest beat %h", $time, got);
        error_count++;
        return;
      end
      exp_b = pending_digest.pop_front();
      if (got.digest_word !== exp_b.digest_word) begin
        $display("%0t: digest_word expected %h actual %h", $time, exp_b.digest_word,
                 got.digest_word);
        error_count++;
      end
      if (got.word_index !== exp_b.word_index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, exp_b.word_index,
                 got.word_index);
        error_count++;
      end
      if (got.last_word !== exp_b.last_word) begin
        $display("%0t: last_word expected %0d actual %0d", $time, exp_b.last_word,
                 got.last_word);
        error_count++;
      end
    endfunction
  endclass
endpackage

FILE: tb/sv/testbench.sv
// Top of the hash engine testbench: clock, reset, beat drivers and the digest monitor.
// Depends on sha512_pkg, the channel interfaces, tb_pkg and the engine RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sha512_pkg::*;
  import tb_pkg::*;

  localparam int DrainCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   beats_sent = 0;
  bit   rx_quiet = 1'b0;

  sha512_in_if  in_ch ();
  sha512_out_if out_ch ();
  sha512_cfg_if cfg_ch ();

  digest_scoreboard sb = new();

  sha512_sha384_hash_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Output side: random stalls per beat, with quiet stretches of no stall.
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      sb.check_output(out_ch.data);
    end
  end

  initial begin : sink_proc
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk_i);
    end
  end

  // Send one message beat after a random gap (none when no_gap is set) and wait for it to be taken.
  task automatic send_beat(logic [63:0] w, int nb, bit last, bit no_gap = 0);
    in_beat_t b;
    int gap;
    b.message_word = w;
    b.valid_bytes = 4'(nb);
    b.last_item = last;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_input(b);
    beats_sent++;
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  // Wait for every digest beat, then let the engine settle before a mode write.
  task automatic drain();
    idle_input();
    @(posedge clk_i);
    while (sb.pending_digest.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= m;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_mode(m);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // A message of n full words and a tail word with tb bytes.
  task automatic send_message(int n, int tb, bit no_gap = 0);
    for (int i = 0; i < n; i++) begin
      send_beat(rand_word(), $urandom_range(0, 15), 1'b0, no_gap);
    end
    send_beat(rand_word(), tb, 1'b1, no_gap);
  endtask

  initial begin : stim_proc
    int n;
    int tb;
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, field extremes, several tail sizes, length boundaries.
    send_beat(64'h0, 0, 1'b1);
    send_beat(64'hffff_ffff_ffff_ffff, 8, 1'b1);
    send_beat(64'hffff_ffff_ffff_ffff, 15, 1'b1);
    send_beat(64'h6162_6300_0000_0000, 3, 1'b1);
    send_beat(64'hffff_ffff_ffff_ffff, 1, 1'b1);
    send_beat(64'hffff_ffff_ffff_ffff, 7, 1'b1);
    send_message(13, 8);
    send_message(14, 0);
    drain();
    write_mode(1'b1);
    send_beat(64'h6162_6300_0000_0000, 3, 1'b1);
    send_beat(64'h0, 0, 1'b1);
    drain();

    // Mode write in the middle of a message drops it.
    for (int i = 0; i < 5; i++) send_beat(rand_word(), 8, 1'b0);
    drain();
    write_mode(1'b0);
    send_beat(64'h0123_4567_89ab_cdef, 9, 1'b1);
    drain();
    write_mode(1'b0);

    // Random phases; the mode write after each phase sets the mode of the next.
    for (int ph = 0; ph < 6; ph++) begin
      rx_quiet = (ph == 2);
      while (beats_sent < 60 * (ph + 1) + 40) begin
        r = $urandom_range(0, 9);
        n = (r < 7) ? $urandom_range(0, 20) : $urandom_range(20, 40);
        tb = $urandom_range(0, 15);
        send_message(n, tb, ph == 2);
      end
      drain();
      write_mode(ph[0]);
    end
    rx_quiet = 1'b0;
    send_message(3, 5);
    drain();
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
